FILE: rtl/rtc_bcd_date_to_epoch_seconds_top_defines.svh
// Assertion macros of the calendar-to-epoch converter, used by rbde_queue.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RTC_BCD_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH
`define RTC_BCD_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define RBDE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbde assertion failed");

// next-cycle implication, off while in reset
`define RBDE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbde assertion failed");

`endif

FILE: rtl/rbde_pkg.sv
// Shared types and constants of the calendar-to-epoch converter.
// No dependencies.
package rbde_pkg;

  localparam int unsigned DEC_W  = 8;   // decoded BCD byte, 0..165
  localparam int unsigned YEAR_W = 15;  // century * 100 + year, up to 16665
  localparam int unsigned PAST_W = 4;   // past months, 0..12

  typedef struct packed {
    logic [DEC_W-1:0]  sec;
    logic [DEC_W-1:0]  min;
    logic [DEC_W-1:0]  hr;
    logic [DEC_W-1:0]  day;
    logic [PAST_W-1:0] past;
    logic [YEAR_W-1:0] year;
  } rbde_item_t;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 15'd1970;
  localparam logic [PAST_W-1:0] MAX_PAST   = 4'd12;

endpackage

FILE: rtl/rbde_if.sv
// Valid/ready channel interfaces of the calendar-to-epoch converter.
// No dependencies.
interface rbde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] seconds_bcd;
  logic [7:0] minutes_bcd;
  logic [7:0] hours_bcd;
  logic [7:0] day_bcd;
  logic [7:0] month_bcd;
  logic [7:0] year_bcd;
  logic [7:0] century_bcd;

  modport source (
    output valid, seconds_bcd, minutes_bcd, hours_bcd, day_bcd, month_bcd,
           year_bcd, century_bcd,
    input  ready
  );
  modport sink (
    input  valid, seconds_bcd, minutes_bcd, hours_bcd, day_bcd, month_bcd,
           year_bcd, century_bcd,
    output ready
  );
endinterface

interface rbde_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface

FILE: rtl/rbde_front.sv
// Front end: takes raw clock register bytes, decodes BCD, forms the full year
// and the clamped past-month count. Depends on rbde_pkg and rbde_in_if.
module rbde_front
  import rbde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rbde_in_if.sink    in_chan,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output rbde_item_t push_item_o
);

  function automatic logic [DEC_W-1:0] bcd_dec(input logic [7:0] b);
    bcd_dec = DEC_W'(b[3:0]) + DEC_W'(b[7:4]) * 8'd10;
  endfunction

  logic             v_r;
  logic             en;
  rbde_item_t       item_r;
  rbde_item_t       item_nxt;
  logic [DEC_W-1:0] mon;
  logic [DEC_W-1:0] yr;
  logic [DEC_W-1:0] cen;

  assign en            = !v_r || push_ready_i;
  assign in_chan.ready = en;
  assign push_valid_o  = v_r;
  assign push_item_o   = item_r;

  always_comb begin
    mon           = bcd_dec(in_chan.month_bcd);
    yr            = bcd_dec(in_chan.year_bcd);
    cen           = bcd_dec(in_chan.century_bcd);
    item_nxt.sec  = bcd_dec(in_chan.seconds_bcd);
    item_nxt.min  = bcd_dec(in_chan.minutes_bcd);
    item_nxt.hr   = bcd_dec(in_chan.hours_bcd);
    item_nxt.day  = bcd_dec(in_chan.day_bcd);
    item_nxt.year = YEAR_W'(cen) * 15'd100 + YEAR_W'(yr);
    if (mon == '0) begin
      item_nxt.past = '0;
    end else if (mon inside {[8'd14:8'd255]}) begin
      item_nxt.past = MAX_PAST;
    end else begin
      item_nxt.past = PAST_W'(mon - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/rbde_queue.sv
// Short FIFO between the front end and the arithmetic back end.
// Depends on rbde_pkg and the assertion macros header.
`include "rtc_bcd_date_to_epoch_seconds_top_defines.svh"
module rbde_queue
  import rbde_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  rbde_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output rbde_item_t pop_item_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rbde_item_t       mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [IDX_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_r != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_r != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  `RBDE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `RBDE_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `RBDE_ASSERT_NXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

FILE: rtl/rbde_back.sv
// Back end: five-stage elastic pipeline from year, month, day and time of day
// to seconds since the epoch. Depends on rbde_pkg and rbde_out_if.
module rbde_back
  import rbde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rbde_item_t in_item_i,
  rbde_out_if.source out_chan
);

  // x / 25 for x below 4167 as (x * 1311) >> 15
  localparam logic [10:0] RECIP25       = 11'd1311;
  localparam int unsigned RECIP_SHIFT   = 15;
  localparam logic [12:0] LEAPS_TO_1969 = 13'd477;
  localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;
  localparam logic [8:0] CUM_DAYS [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
    9'd273, 9'd304, 9'd334, 9'd365
  };

  logic en1, en2, en3, en4, en5;
  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r, out_v_r;

  // stage 1
  logic [YEAR_W-1:0] b1_year_r;
  logic [12:0]       b1_q4_r, b1_yq4_r;
  logic [23:0]       b1_qprod_r, b1_yprod_r;
  logic [8:0]        b1_cum_r;
  logic [PAST_W-1:0] b1_past_r;
  logic [DEC_W-1:0]  b1_day_r, b1_sec_r, b1_min_r, b1_hr_r;
  logic [12:0]       q4_nxt, yq4_nxt;

  // stage 2
  logic [22:0] b2_ydays_r, ydays_nxt;
  logic [8:0]  b2_mdays_r, mdays_nxt;
  logic [7:0]  b2_day_r;
  logic [19:0] b2_tsec_r, tsec_nxt;
  logic [8:0]  q100, yq100;
  logic [12:0] leaps;
  logic [12:0] ymod25;
  logic        leap;
  logic [22:0] ybase;

  // stages 3 to 5
  logic signed [23:0] b3_days_r, days_nxt;
  logic [19:0]        b3_tsec_r, b4_tsec_r;
  logic signed [41:0] b4_prod_r;
  logic [63:0]        out_sec_r;

  assign en5        = !out_v_r || out_chan.ready;
  assign en4        = !b4_v_r || en5;
  assign en3        = !b3_v_r || en4;
  assign en2        = !b2_v_r || en3;
  assign en1        = !b1_v_r || en2;
  assign in_ready_o = en1;

  assign out_chan.valid         = out_v_r;
  assign out_chan.epoch_seconds = out_sec_r;

  always_comb begin
    q4_nxt  = 13'((in_item_i.year - 15'd1) >> 2);
    yq4_nxt = 13'(in_item_i.year >> 2);
  end

  always_comb begin
    q100   = b1_qprod_r[RECIP_SHIFT +: 9];
    yq100  = b1_yprod_r[RECIP_SHIFT +: 9];
    leaps  = b1_q4_r - {4'b0, q100} + {6'b0, q100[8:2]} - LEAPS_TO_1969;
    ymod25 = b1_yq4_r - {4'b0, yq100} * 13'd25;
    leap   = (b1_year_r[1:0] == 2'b00) && ((ymod25 != '0) || (yq100[1:0] == 2'b00));
    ybase  = 23'(b1_year_r - EPOCH_YEAR) * 23'd365;
    ydays_nxt = (b1_year_r > EPOCH_YEAR) ? ybase + {10'b0, leaps} : '0;
    mdays_nxt = b1_cum_r + {8'b0, leap && (b1_past_r >= 4'd2)};
    tsec_nxt  = 20'(b1_hr_r) * 20'd3600 + 20'(b1_min_r) * 20'd60 + 20'(b1_sec_r);
  end

  assign days_nxt = $signed({1'b0, b2_ydays_r}) + $signed({15'b0, b2_mdays_r})
                  + $signed({16'b0, b2_day_r}) - 24'sd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        b1_v_r <= in_valid_i;
      end
      if (en2) begin
        b2_v_r <= b1_v_r;
      end
      if (en3) begin
        b3_v_r <= b2_v_r;
      end
      if (en4) begin
        b4_v_r <= b3_v_r;
      end
      if (en5) begin
        out_v_r <= b4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      b1_year_r  <= in_item_i.year;
      b1_q4_r    <= q4_nxt;
      b1_yq4_r   <= yq4_nxt;
      b1_qprod_r <= 24'(q4_nxt) * 24'(RECIP25);
      b1_yprod_r <= 24'(yq4_nxt) * 24'(RECIP25);
      b1_cum_r   <= CUM_DAYS[in_item_i.past];
      b1_past_r  <= in_item_i.past;
      b1_day_r   <= in_item_i.day;
      b1_sec_r   <= in_item_i.sec;
      b1_min_r   <= in_item_i.min;
      b1_hr_r    <= in_item_i.hr;
    end
    if (en2) begin
      b2_ydays_r <= ydays_nxt;
      b2_mdays_r <= mdays_nxt;
      b2_day_r   <= b1_day_r;
      b2_tsec_r  <= tsec_nxt;
    end
    if (en3) begin
      b3_days_r <= days_nxt;
      b3_tsec_r <= b2_tsec_r;
    end
    if (en4) begin
      b4_prod_r <= b3_days_r * SECS_PER_DAY;
      b4_tsec_r <= b3_tsec_r;
    end
    if (en5) begin
      out_sec_r <= {{22{b4_prod_r[41]}}, b4_prod_r} + {44'b0, b4_tsec_r};
    end
  end

endmodule

FILE: rtl/rtc_bcd_date_to_epoch_seconds_top.sv
// Path of an item: front register, queue, four arithmetic stages, output
// register. Throughput: one item per cycle while results are taken; the
// queue and every stage are elastic. Stalls on the result side back up
// through the stages into the queue.
// Reset (synchronous, active low) empties the queue and all stages.
module rtc_bcd_date_to_epoch_seconds_top
  import rbde_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  rbde_in_if.sink     in_chan,
  rbde_out_if.source  out_chan
);

  logic       f_valid, f_ready;
  rbde_item_t f_item;
  logic       q_valid, q_ready;
  rbde_item_t q_item;

  rbde_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_item_o  (f_item)
  );

  rbde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  rbde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .in_item_i  (q_item),
    .out_chan   (out_chan)
  );

endmodule

FILE: tb/sv/rtc_bcd_date_to_epoch_seconds_top_tb.sv
// Testbench for the RTC calendar-to-epoch converter: drives raw BCD register
// bytes, predicts seconds since 1970 and checks every result in order.
// Depends on rbde_pkg, the rbde_in_if/rbde_out_if interfaces and the top level.
`timescale 1ns / 100ps

module rtc_bcd_date_to_epoch_seconds_top_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam bit [63:0] EPOCH_YEAR_NUM = 64'd1970;
  localparam bit [4:0] MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    bit [7:0] sec;
    bit [7:0] min;
    bit [7:0] hr;
    bit [7:0] day;
    bit [7:0] mon;
    bit [7:0] yr;
    bit [7:0] cen;
  } clock_regs_t;

  logic clk;
  logic rst_n;

  rbde_in_if  in_if ();
  rbde_out_if out_if ();

  rtc_bcd_date_to_epoch_seconds_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  bit [63:0] expected_epochs [$];
  int unsigned fail_count;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned cycle_count;
  bit idle_on;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned sink_gap;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [63:0] bcd_value(input bit [7:0] b);
    return 64'(b[3:0]) + 64'(b[7:4]) * 64'd10;
  endfunction

  function automatic bit gregorian_leap(input bit [63:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic bit [63:0] leaps_through(input bit [63:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit [63:0] epoch_of(input clock_regs_t r);
    bit [63:0] mon;
    bit [63:0] year;
    bit [63:0] days;
    bit [63:0] past;
    int unsigned m;
    mon = bcd_value(r.mon);
    year = bcd_value(r.cen) * 64'd100 + bcd_value(r.yr);
    days = 64'd0;
    if (year > EPOCH_YEAR_NUM) begin
      days = 64'd365 * (year - EPOCH_YEAR_NUM) + leaps_through(year - 64'd1)
           - leaps_through(EPOCH_YEAR_NUM - 64'd1);
    end
    past = (mon == 64'd0) ? 64'd0 : mon - 64'd1;
    if (past > 64'd12) begin
      past = 64'd12;
    end
    for (m = 0; m < past; m++) begin
      days += 64'(MONTH_DAYS[m]);
      if (m == 1 && gregorian_leap(year)) begin
        days += 64'd1;
      end
    end
    days = days + bcd_value(r.day) - 64'd1;
    return days * 64'd86400 + bcd_value(r.hr) * 64'd3600 + bcd_value(r.min) * 64'd60
         + bcd_value(r.sec);
  endfunction

  function automatic bit [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // record accepted items and check results at the same edge
  always @(posedge clk) begin
    clock_regs_t regs;
    bit [63:0] want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        regs = '{in_if.seconds_bcd, in_if.minutes_bcd, in_if.hours_bcd, in_if.day_bcd,
                 in_if.month_bcd, in_if.year_bcd, in_if.century_bcd};
        expected_epochs.push_back(epoch_of(regs));
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_epochs.size() == 0) begin
          $error("epoch_seconds: no item pending, actual %0d", out_if.epoch_seconds);
          fail_count++;
        end else begin
          want = expected_epochs.pop_front();
          results_checked++;
          if (out_if.epoch_seconds !== want) begin
            $error("epoch_seconds mismatch: expected %0d, actual %0d", want,
                   out_if.epoch_seconds);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: long holds on request, random short stalls while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic offer_clock_regs(input bit [7:0] sec, input bit [7:0] min,
                                  input bit [7:0] hr, input bit [7:0] day,
                                  input bit [7:0] mon, input bit [7:0] yr,
                                  input bit [7:0] cen);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.seconds_bcd <= sec;
    in_if.minutes_bcd <= min;
    in_if.hours_bcd   <= hr;
    in_if.day_bcd     <= day;
    in_if.month_bcd   <= mon;
    in_if.year_bcd    <= yr;
    in_if.century_bcd <= cen;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_epochs.size() != 0) @(posedge clk);
  endtask

  task automatic offer_random_item();
    int unsigned kind;
    clock_regs_t r;
    kind = $urandom_range(0, 9);
    r.sec = to_bcd($urandom_range(0, 59));
    r.min = to_bcd($urandom_range(0, 59));
    r.hr  = to_bcd($urandom_range(0, 23));
    r.day = to_bcd($urandom_range(1, 31));
    r.mon = to_bcd($urandom_range(1, 12));
    r.yr  = to_bcd($urandom_range(0, 99));
    r.cen = ($urandom_range(0, 3) == 0) ? to_bcd($urandom_range(0, 99))
                                        : to_bcd($urandom_range(19, 21));
    if (kind >= 8) begin
      r = clock_regs_t'(56'({$urandom, $urandom}));
    end else if (kind >= 6) begin
      case ($urandom_range(0, 6))
        0: r.sec = 8'($urandom);
        1: r.min = 8'($urandom);
        2: r.hr  = 8'($urandom);
        3: r.day = 8'($urandom);
        4: r.mon = 8'($urandom);
        5: r.yr  = 8'($urandom);
        default: r.cen = 8'($urandom);
      endcase
    end
    offer_clock_regs(r.sec, r.min, r.hr, r.day, r.mon, r.yr, r.cen);
  endtask

  task automatic test_calendar_dates();
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h71, 8'h19);
    offer_clock_regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19);
    offer_clock_regs(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h24, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h19);
    offer_clock_regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99);
    offer_clock_regs(8'h60, 8'h59, 8'h23, 8'h28, 8'h02, 8'h23, 8'h20);
  endtask

  task automatic test_corner_bytes();
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_clock_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_clock_regs(8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h14, 8'h00, 8'h20);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h0F, 8'h96, 8'h19);
    offer_clock_regs(8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h0A, 8'h9F, 8'hF9);
    offer_clock_regs(8'h55, 8'hA5, 8'h5A, 8'h0E, 8'hF0, 8'h50, 8'h0F);
    offer_clock_regs(8'h00, 8'h00, 8'h00, 8'h15, 8'h06, 8'h50, 8'h00);
  endtask

  task automatic test_result_backpressure();
    hold_requests++;
    repeat (30) offer_random_item();
  endtask

  task automatic test_sender_pause();
    repeat (12) offer_random_item();
    wait_for_drain();
    repeat (12) offer_random_item();
  endtask

  task automatic test_random_items(input int unsigned count);
    repeat (count) offer_random_item();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    idle_on = 1'b0;
    in_if.valid <= 1'b0;
    in_if.seconds_bcd <= 8'h00;
    in_if.minutes_bcd <= 8'h00;
    in_if.hours_bcd <= 8'h00;
    in_if.day_bcd <= 8'h01;
    in_if.month_bcd <= 8'h01;
    in_if.year_bcd <= 8'h70;
    in_if.century_bcd <= 8'h19;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_dates();
    idle_on = 1'b1;
    test_corner_bytes();
    test_result_backpressure();
    test_sender_pause();
    test_random_items(820);
    idle_on = 1'b0;
    test_random_items(150);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d register sets, %0d results checked: calendar edges, leap rules,",
             items_accepted, results_checked);
    $display("bad BCD, month clamp, day zero, random dates and raw bytes under stalls.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
